/* rtl/lgh_pkg.sv */
// ----------------------------------------------------------------------------
// lgh_pkg
// Shared types and constants for the Lehmer generator with histogram.
// ----------------------------------------------------------------------------
package lgh_pkg;

  localparam int unsigned VAL_W  = 31;  // generator value and register width
  localparam int unsigned BIN_W  = 5;   // bin field width on the stream
  localparam int unsigned CNT_W  = 32;  // histogram count width
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned IDX_W  = 5;   // bin_index field width
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned REG_W  = 2;   // configuration index width

  localparam logic [VAL_W-1:0] MULT_RST = 31'd16807;
  localparam logic [VAL_W-1:0] MOD_RST  = 31'd2147483647;
  localparam logic [VAL_W-1:0] SEED_RST = 31'd12345;

  localparam logic [REG_W-1:0] REG_MULT = 2'd0;
  localparam logic [REG_W-1:0] REG_MOD  = 2'd1;
  localparam logic [REG_W-1:0] REG_SEED = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_GEN     = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_UPD,
    ST_OUT
  } state_e;

endpackage

/* rtl/lgh_ram.sv */
// ----------------------------------------------------------------------------
// lgh_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lgh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lgh_modred.sv */
// ----------------------------------------------------------------------------
// lgh_modred
// Multiplies the value by the multiplier, then reduces the 62-bit product
// modulo the modulus one bit per cycle (restoring remainder).
// ----------------------------------------------------------------------------
module lgh_modred (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [lgh_pkg::VAL_W-1:0] mult_i,
  input  logic [lgh_pkg::VAL_W-1:0] value_i,
  input  logic [lgh_pkg::VAL_W-1:0] mod_i,
  output logic                  busy_o,
  output logic [lgh_pkg::VAL_W-1:0] rem_o
);
  import lgh_pkg::*;

  localparam int unsigned CW = $clog2(PROD_W);

  logic              busy_q;
  logic [CW-1:0]     cnt_q;
  logic [PROD_W-1:0] prod_q;
  logic [VAL_W-1:0]  rem_q;
  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    diff;
  logic              ge;

  // shift the next product bit into the partial remainder
  assign trial = {rem_q, prod_q[PROD_W-1]};
  assign ge    = trial >= {1'b0, mod_i};
  assign diff  = trial - {1'b0, mod_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= (mod_i != '0);
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(PROD_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PROD_W'(mult_i) * PROD_W'(value_i);
      rem_q  <= '0;
    end else if (busy_q) begin
      prod_q <= {prod_q[PROD_W-2:0], 1'b0};
      rem_q  <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/lgh_bindiv.sv */
// ----------------------------------------------------------------------------
// lgh_bindiv
// Bin of a value: floor(NUM_BINS * value / modulus) by long division,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lgh_bindiv #(
  parameter int unsigned NUM_BINS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lgh_pkg::VAL_W-1:0]     value_i,
  input  logic [lgh_pkg::VAL_W-1:0]     mod_i,
  output logic                          busy_o,
  output logic [$clog2(NUM_BINS)-1:0]   bin_o
);
  import lgh_pkg::*;

  localparam int unsigned QW = $clog2(NUM_BINS);
  localparam int unsigned NW = VAL_W + QW;
  localparam int unsigned CW = $clog2(QW + 1);
  localparam logic [QW-1:0] LAST_BIN = QW'(NUM_BINS - 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] num_q;
  logic [NW-1:0] div_q;
  logic [QW-1:0] quo_q;
  logic          ge;
  logic          saturate;

  assign ge       = num_q >= div_q;
  // value at or above the modulus, or no modulus: top bin
  assign saturate = (mod_i == '0) || (value_i >= mod_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= !saturate;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(QW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= NW'(NUM_BINS) * NW'(value_i);
      div_q <= NW'(mod_i) << (QW - 1);
      quo_q <= saturate ? LAST_BIN : '0;
    end else if (busy_q) begin
      num_q <= ge ? (num_q - div_q) : num_q;
      div_q <= div_q >> 1;
      quo_q <= QW'({quo_q, ge});
    end
  end

  assign busy_o = busy_q;
  assign bin_o  = (32'(quo_q) >= NUM_BINS) ? LAST_BIN : quo_q;

endmodule

/* rtl/lehmer_generator_with_histogram_core.sv */
// ----------------------------------------------------------------------------
// lehmer_generator_with_histogram_core
// Multiplicative congruential generator with a histogram of emitted values.
// ----------------------------------------------------------------------------
// Input requests arrive on s_axis (cmd, bin_index); every request returns one
// result on m_axis (value, bin, count).
//   generate: emits the current value and its bin, bumps that bin's count
//     (saturating) and advances the value to multiplier * value mod modulus.
//   read:     returns the count of bin_index (zero beyond the last bin).
//   restart:  reloads the seed and clears every count.
// Configuration (multiplier, modulus, seed) is written through cfg_* while
// the core is idle.
// Generate waits for the bit-serial 62-bit modular reduction and then, like
// read, passes through the RAM read and update states; restart and the unused
// code go straight to the output. One request is in flight at a time; the next
// is taken the cycle after its result is loaded.
// The counts live in a RAM; per-bin valid flops mark cleared entries, so
// reset and restart take effect at once with no clearing pass.
// A stalled receiver holds the result in the output register; one further
// request is still worked off and then waits until that register frees.
// ----------------------------------------------------------------------------
module lehmer_generator_with_histogram_core #(
  parameter int unsigned NUM_BINS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  // requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // cmd[1:0], bin_index[6:2], zero[7]
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // value[30:0], bin[35:31], count[67:36],
                                      // zero[71:68]
);
  import lgh_pkg::*;

  localparam int unsigned BW = $clog2(NUM_BINS);

  state_e            state_q, state_d;
  cmd_e              cmd_q;
  logic [BW-1:0]     addr_q;
  logic              in_range_q;
  logic [VAL_W-1:0]  mult_q, mod_q, seed_q, cur_q;
  logic [NUM_BINS-1:0] vld_q;
  logic [VAL_W-1:0]  res_value_q;
  logic [BIN_W-1:0]  res_bin_q;
  logic [CNT_W-1:0]  res_count_q;
  logic              m_valid_q;
  logic [VAL_W-1:0]  out_value_q;
  logic [BIN_W-1:0]  out_bin_q;
  logic [CNT_W-1:0]  out_count_q;

  logic              in_fire;
  logic              out_free;
  logic [CMD_W-1:0]  in_cmd;
  logic [IDX_W-1:0]  in_idx;
  logic              in_ok;
  logic              unit_start;
  logic              units_busy;
  logic              ram_we;
  logic              load_out;
  logic              mr_busy, bd_busy;
  logic [VAL_W-1:0]  mr_rem;
  logic [BW-1:0]     bd_bin;
  logic [CNT_W-1:0]  rd_data;
  logic [CNT_W-1:0]  cnt_cur;
  logic [CNT_W-1:0]  cnt_inc;

  assign in_cmd  = s_axis_tdata[1:0];
  assign in_idx  = s_axis_tdata[6:2];
  assign in_ok   = 32'(in_idx) < NUM_BINS;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign units_busy = mr_busy || bd_busy;

  // never-written entries read as zero
  assign cnt_cur = vld_q[addr_q] ? rd_data : '0;
  assign cnt_inc = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;

  lgh_modred u_modred (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .mult_i  (mult_q),
    .value_i (cur_q),
    .mod_i   (mod_q),
    .busy_o  (mr_busy),
    .rem_o   (mr_rem)
  );

  lgh_bindiv #(
    .NUM_BINS (NUM_BINS)
  ) u_bindiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .value_i (cur_q),
    .mod_i   (mod_q),
    .busy_o  (bd_busy),
    .bin_o   (bd_bin)
  );

  lgh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (cnt_inc),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd_e'(in_cmd))
            CMD_GEN:  state_d = ST_CALC;
            CMD_READ: state_d = ST_READ;
            default:  state_d = ST_OUT;
          endcase
        end
      end
      ST_CALC: begin
        if (!units_busy) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_UPD;
      ST_UPD:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    unit_start    = 1'b0;
    ram_we        = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        unit_start    = s_axis_tvalid && (cmd_e'(in_cmd) == CMD_GEN);
      end
      ST_UPD:  ram_we   = (cmd_q == CMD_GEN);
      ST_OUT:  load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mult_q    <= MULT_RST;
      mod_q     <= MOD_RST;
      seed_q    <= SEED_RST;
      cur_q     <= SEED_RST;
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MULT: mult_q <= cfg_wdata_i;
          REG_MOD:  mod_q  <= cfg_wdata_i;
          REG_SEED: seed_q <= cfg_wdata_i;
          default:  ;
        endcase
      end
      if (in_fire && (cmd_e'(in_cmd) == CMD_RESTART)) begin
        cur_q <= seed_q;
        vld_q <= '0;
      end
      if (ram_we) begin
        cur_q         <= mr_rem;
        vld_q[addr_q] <= 1'b1;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q       <= cmd_e'(in_cmd);
      addr_q      <= in_ok ? BW'(in_idx) : '0;
      in_range_q  <= in_ok;
      res_value_q <= (cmd_e'(in_cmd) == CMD_GEN) ? cur_q : '0;
      res_bin_q   <= '0;
      res_count_q <= '0;
    end
    if ((state_q == ST_CALC) && !units_busy) begin
      addr_q    <= bd_bin;
      res_bin_q <= BIN_W'(bd_bin);
    end
    if ((state_q == ST_UPD) && (cmd_q == CMD_READ)) begin
      res_count_q <= in_range_q ? cnt_cur : '0;
    end
    if (load_out) begin
      out_value_q <= res_value_q;
      out_bin_q   <= res_bin_q;
      out_count_q <= res_count_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0, out_count_q, out_bin_q, out_value_q};

endmodule

/* dv/lehmer_generator_with_histogram_core_test.sv */
// ----------------------------------------------------------------------------
// lehmer_generator_with_histogram_core_test
// Self-checking bench for the Lehmer generator with histogram. Requests are
// driven on s_axis and results are taken from m_axis, both with random gaps.
// A scoreboard keeps its own copy of the generator, the histogram and the
// configuration. It works out the result of each accepted request and checks
// every result, field by field, in order. The run starts with directed
// requests and special configurations, then moves on to random phases. Each
// random phase has its own configuration.
// ----------------------------------------------------------------------------
module lehmer_generator_with_histogram_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lgh_pkg::*;

  localparam int unsigned NUM_BINS = 20;
  localparam logic [REG_W-1:0] REG_SPARE = 2'd3;  // unmapped index, writes dropped
  localparam int unsigned IDLE_MAX    = 16;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 165;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  // last field in the lowest bits, as on m_axis_tdata
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [BIN_W-1:0] bin;
    logic [VAL_W-1:0] value;
  } result_t;

  class histogram_scoreboard;
    logic [VAL_W-1:0] mult;
    logic [VAL_W-1:0] modulus;
    logic [VAL_W-1:0] seed;
    logic [VAL_W-1:0] cur_value;
    logic [CNT_W-1:0] counts [NUM_BINS];
    result_t          expected_q [$];
    int               errors;

    function new();
      mult      = MULT_RST;
      modulus   = MOD_RST;
      seed      = SEED_RST;
      cur_value = SEED_RST;
      foreach (counts[i]) counts[i] = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [REG_W-1:0] idx, logic [VAL_W-1:0] data);
      case (idx)
        REG_MULT: mult    = data;
        REG_MOD:  modulus = data;
        REG_SEED: seed    = data;
        default: ;
      endcase
    endfunction

    function logic [BIN_W-1:0] bin_of(logic [VAL_W-1:0] x);
      logic [63:0] q;
      if (modulus == '0 || x >= modulus) return BIN_W'(NUM_BINS - 1);
      q = (64'(NUM_BINS) * 64'(x)) / 64'(modulus);
      if (q >= 64'(NUM_BINS)) q = 64'(NUM_BINS - 1);
      return q[BIN_W-1:0];
    endfunction

    function logic [VAL_W-1:0] next_value(logic [VAL_W-1:0] x);
      logic [63:0] p;
      if (modulus == '0) return '0;
      p = (64'(mult) * 64'(x)) % 64'(modulus);
      return p[VAL_W-1:0];
    endfunction

    function void note_request(cmd_e cmd, logic [IDX_W-1:0] idx);
      result_t r;
      r = '0;
      case (cmd)
        CMD_GEN: begin
          r.value = cur_value;
          r.bin   = bin_of(cur_value);
          if (counts[r.bin] != '1) counts[r.bin] = counts[r.bin] + 1;
          cur_value = next_value(cur_value);
        end
        CMD_READ: begin
          if (32'(idx) < NUM_BINS) r.count = counts[idx];
        end
        CMD_RESTART: begin
          cur_value = seed;
          foreach (counts[i]) counts[i] = '0;
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: value %0d bin %0d count %0d",
               got.value, got.bin, got.count);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %0d, actual %0d", want.value, got.value);
        errors++;
      end
      if (got.bin !== want.bin) begin
        $error("bin: expected %0d, actual %0d", want.bin, got.bin);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [30:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // cmd[1:0], bin_index[6:2], zero[7]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // value[30:0], bin[35:31], count[67:36], zero[71:68]

  histogram_scoreboard sb;
  bit                  no_idle;
  int unsigned         quiet_cycles;

  lehmer_generator_with_histogram_core #(
    .NUM_BINS(NUM_BINS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high.
  task automatic send_request(cmd_e cmd, logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, idx, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, idx);
    @(negedge clk_i);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    cmd_e        cmd;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    if (pick < 65)      cmd = CMD_GEN;
    else if (pick < 85) cmd = CMD_READ;
    else if (pick < 93) cmd = CMD_RESTART;
    else                cmd = CMD_NOP;
    if ($urandom_range(0, 3) == 0) idx = IDX_W'($urandom_range(0, 31));
    else                           idx = IDX_W'($urandom_range(0, NUM_BINS - 1));
    send_request(cmd, idx);
  endtask

  // Hold off new requests until every result is back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic configure(logic [VAL_W-1:0] mult, logic [VAL_W-1:0] modulus,
                           logic [VAL_W-1:0] seed);
    logic [REG_W-1:0] idx_list [4];
    logic [VAL_W-1:0] data_list [4];
    idx_list  = '{REG_SPARE, REG_MULT, REG_MOD, REG_SEED};
    data_list = '{VAL_W'($urandom), mult, modulus, seed};
    foreach (idx_list[i]) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx_list[i];
      cfg_wdata_i <= data_list[i];
      @(posedge clk_i);
      sb.write_reg(idx_list[i], data_list[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] odd_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return VAL_MAX;
      2:       return VAL_W'($urandom_range(0, 50));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [VAL_W-1:0] mult;
    logic [VAL_W-1:0] modulus;
    logic [VAL_W-1:0] seed;
    sb            = new();
    no_idle       = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration: reads, bin edges, unused command, restart
    send_request(CMD_READ, 5'd0);
    send_request(CMD_GEN, 5'd31);
    send_request(CMD_GEN, 5'd0);
    send_request(CMD_READ, 5'd0);
    send_request(CMD_READ, 5'd1);
    send_request(CMD_READ, 5'd20);
    send_request(CMD_READ, 5'd31);
    send_request(CMD_NOP, 5'd31);
    send_request(CMD_RESTART, 5'd10);
    send_request(CMD_GEN, 5'd21);

    // smallest multiplier and modulus
    drain();
    configure(31'd2, 31'd3, 31'd1);
    send_request(CMD_RESTART, 5'd0);
    send_request(CMD_GEN, 5'd0);
    send_request(CMD_GEN, 5'd0);
    send_request(CMD_READ, 5'd13);

    // largest registers
    drain();
    configure(31'd2147483646, VAL_MAX, 31'd2147483646);
    send_request(CMD_RESTART, 5'd0);
    send_request(CMD_GEN, 5'd0);
    send_request(CMD_GEN, 5'd0);

    // seed above modulus lands in the top bin
    drain();
    configure(31'd16807, 31'd1000, VAL_MAX);
    send_request(CMD_RESTART, 5'd0);
    send_request(CMD_GEN, 5'd0);

    // value collapses to zero and stays there
    drain();
    configure(31'd97, 31'd97, 31'd5);
    send_request(CMD_RESTART, 5'd0);
    send_request(CMD_GEN, 5'd0);
    send_request(CMD_GEN, 5'd0);

    // modulus zero, carried value without restart
    drain();
    configure(31'd16807, 31'd0, 31'd12345);
    send_request(CMD_GEN, 5'd0);
    send_request(CMD_GEN, 5'd0);
    send_request(CMD_READ, 5'd19);

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: begin
          mult    = odd_value();
          modulus = odd_value();
          seed    = odd_value();
        end
        1, 2: begin
          modulus = VAL_W'($urandom_range(3, 1000));
          mult    = VAL_W'($urandom_range(2, modulus - 1));
          seed    = VAL_W'($urandom_range(1, modulus - 1));
        end
        default: begin
          modulus = VAL_W'($urandom_range(3, 32'h7FFF_FFFF));
          mult    = VAL_W'($urandom_range(2, modulus - 1));
          seed    = VAL_W'($urandom_range(1, modulus - 1));
        end
      endcase
      configure(mult, modulus, seed);
      if ($urandom_range(0, 3) != 0) send_request(CMD_RESTART, IDX_W'($urandom));
      repeat (PHASE_ITEMS) send_random_request();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side: stall at random ahead of each result
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata[67:0]);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* files.f */
rtl/lgh_pkg.sv
rtl/lgh_ram.sv
rtl/lgh_modred.sv
rtl/lgh_bindiv.sv
rtl/lehmer_generator_with_histogram_core.sv
dv/lehmer_generator_with_histogram_core_test.sv
